// ===== hw/rtl/chacha_keystream_cipher_macros.svh =====
// Assertion macros shared by the ChaCha keystream cipher RTL.
// Included by the top level; depends on nothing else.
`ifndef CHACHA_KEYSTREAM_CIPHER_MACROS_SVH
`define CHACHA_KEYSTREAM_CIPHER_MACROS_SVH

// Same-cycle implication under the asynchronous reset.
`define CKC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the asynchronous reset.
`define CKC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ckc_pkg.sv =====
// Shared types and constants of the ChaCha keystream cipher.
// Used by ckc_ctrl, ckc_datapath and chacha_keystream_cipher; depends on nothing.
package ckc_pkg;

	localparam logic [6:0] MAX_BYTES = 7'd64;

	// ChaCha state as sixteen 32-bit words, word 0 in the lowest bits.
	typedef logic [15:0][31:0] ckc_state_t;
	// One 64-byte message block as eight little-endian 64-bit words.
	typedef logic [7:0][63:0] ckc_block_t;

	// "expand 32-byte k" and "expand 16-byte k", word 0 lowest.
	localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
		32'h3320646e, 32'h61707865};
	localparam logic [3:0][31:0] TAU = {32'h6b206574, 32'h79622d36,
		32'h3120646e, 32'h61707865};

	typedef enum logic [2:0] {
		REG_KEY_LOW_A  = 3'd0,
		REG_KEY_LOW_B  = 3'd1,
		REG_KEY_HIGH_A = 3'd2,
		REG_KEY_HIGH_B = 3'd3,
		REG_LONG_KEY   = 3'd4,
		REG_NONCE      = 3'd5
	} ckc_reg_t;

	typedef struct packed {
		logic [63:0] key_low_a;
		logic [63:0] key_low_b;
		logic [63:0] key_high_a;
		logic [63:0] key_high_b;
		logic        long_key;
		logic [63:0] nonce;
	} ckc_cfg_t;

	typedef struct packed {
		logic load;    // capture an input block and build the initial state
		logic step;    // apply one column or diagonal round
		logic diag;    // the round being applied is a diagonal round
		logic finish;  // feed-forward add, XOR, mask and fill the output register
	} ckc_cmd_t;

	typedef struct packed {
		logic empty;   // the loaded block holds no valid byte
	} ckc_stat_t;

endpackage

// ===== hw/rtl/ckc_ctrl.sv =====
// Sequencer of the ChaCha keystream cipher: load, round iteration, finish.
// Depends on ckc_pkg for the command and status structs.
module ckc_ctrl import ckc_pkg::*; #(
	parameter int ROUNDS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      m_tready,
	input  ckc_stat_t stat,
	output ckc_cmd_t  cmd,
	output logic      s_tready,
	output logic      m_tvalid
);

	localparam int RW = $clog2(ROUNDS);
	localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL
	} state_t;

	state_t        state_q;
	logic [RW-1:0] round_q;
	logic          out_valid_q;
	logic          out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid;
			end
			ST_ROUND: begin
				cmd.step = !stat.empty;
				cmd.diag = round_q[0];
			end
			ST_FINAL: begin
				cmd.finish = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one being taken by the sink in the same cycle.
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_ROUND;
						round_q <= '0;
					end
				end
				ST_ROUND: begin
					if (stat.empty || round_q == LAST_ROUND) begin
						state_q <= ST_FINAL;
					end else begin
						round_q <= round_q + 1'b1;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/ckc_datapath.sv =====
// Datapath of the ChaCha keystream cipher: state words, four quarter-round
// lanes, block counter, feed-forward add and output masking. Depends on ckc_pkg.
module ckc_datapath import ckc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ckc_cmd_t   cmd,
	input  ckc_cfg_t   cfg,
	input  ckc_block_t msg,
	input  logic [6:0] valid_bytes,
	input  logic       restart,
	output ckc_stat_t  stat,
	output ckc_block_t out_words,
	output logic [6:0] out_valid_bytes
);

	ckc_state_t  w_q;
	ckc_state_t  w_nxt;
	ckc_block_t  msg_q;
	logic [6:0]  n_q;
	logic [63:0] ctr_q;
	logic [63:0] ld_ctr;
	logic [6:0]  n_sat;
	ckc_state_t  init_cur;
	ckc_state_t  ks;
	ckc_block_t  ks_blk;
	ckc_block_t  res;
	ckc_block_t  out_word_q;
	logic [6:0]  out_n_q;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [3:0][31:0] qr(input logic [31:0] a_in,
		input logic [31:0] b_in, input logic [31:0] c_in, input logic [31:0] d_in);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		a = a_in;
		b = b_in;
		c = c_in;
		d = d_in;
		a = a + b; d = rotl(d ^ a, 16);
		c = c + d; b = rotl(b ^ c, 12);
		a = a + b; d = rotl(d ^ a, 8);
		c = c + d; b = rotl(b ^ c, 7);
		return {d, c, b, a};
	endfunction

	function automatic ckc_state_t init_state(input ckc_cfg_t c, input logic [63:0] ctr);
		ckc_state_t  s;
		logic [3:0][31:0] cst;
		logic [63:0] k2;
		logic [63:0] k3;
		cst = c.long_key ? SIGMA : TAU;
		k2  = c.long_key ? c.key_high_a : c.key_low_a;
		k3  = c.long_key ? c.key_high_b : c.key_low_b;
		s[0]  = cst[0];
		s[1]  = cst[1];
		s[2]  = cst[2];
		s[3]  = cst[3];
		s[4]  = c.key_low_a[31:0];
		s[5]  = c.key_low_a[63:32];
		s[6]  = c.key_low_b[31:0];
		s[7]  = c.key_low_b[63:32];
		s[8]  = k2[31:0];
		s[9]  = k2[63:32];
		s[10] = k3[31:0];
		s[11] = k3[63:32];
		s[12] = ctr[31:0];
		s[13] = ctr[63:32];
		s[14] = c.nonce[31:0];
		s[15] = c.nonce[63:32];
		return s;
	endfunction

	assign ld_ctr     = restart ? '0 : ctr_q;
	assign n_sat      = (valid_bytes > MAX_BYTES) ? MAX_BYTES : valid_bytes;
	assign stat.empty = (n_q == '0);
	assign init_cur   = init_state(cfg, ctr_q);

	// One column or diagonal round: four independent quarter-round lanes.
	always_comb begin
		logic [3:0][31:0] r;
		logic [3:0] ia;
		logic [3:0] ib;
		logic [3:0] ic;
		logic [3:0] id;
		w_nxt = w_q;
		r  = '0;
		ia = '0;
		ib = '0;
		ic = '0;
		id = '0;
		for (int i = 0; i < 4; i++) begin
			ia = 4'(i);
			ib = cmd.diag ? 4'(4 + ((i + 1) & 3)) : 4'(4 + i);
			ic = cmd.diag ? 4'(8 + ((i + 2) & 3)) : 4'(8 + i);
			id = cmd.diag ? 4'(12 + ((i + 3) & 3)) : 4'(12 + i);
			r  = qr(w_q[ia], w_q[ib], w_q[ic], w_q[id]);
			w_nxt[ia] = r[0];
			w_nxt[ib] = r[1];
			w_nxt[ic] = r[2];
			w_nxt[id] = r[3];
		end
	end

	// Feed-forward add, XOR with the message and zero the bytes past the count.
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			ks[k] = w_q[k] + init_cur[k];
		end
		// Keystream word j pairs state words 2j (low half) and 2j+1 (high half).
		ks_blk = ks;
		for (int j = 0; j < 8; j++) begin
			for (int bt = 0; bt < 8; bt++) begin
				res[j][8*bt +: 8] = (7'(8 * j + bt) < n_q) ?
					(msg_q[j][8*bt +: 8] ^ ks_blk[j][8*bt +: 8]) : 8'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q   <= init_state(cfg, ld_ctr);
			msg_q <= msg;
			n_q   <= n_sat;
		end else if (cmd.step) begin
			w_q <= w_nxt;
		end
		if (cmd.finish) begin
			out_word_q <= res;
			out_n_q    <= n_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (cmd.load && restart) begin
			ctr_q <= '0;
		end else if (cmd.finish && !stat.empty) begin
			ctr_q <= ctr_q + 64'd1;
		end
	end

	assign out_words       = out_word_q;
	assign out_valid_bytes = out_n_q;

endmodule

// ===== hw/rtl/chacha_keystream_cipher.sv =====
// ChaCha keystream cipher top level: configuration registers, sequencer and datapath.
// Depends on ckc_pkg, ckc_ctrl, ckc_datapath and chacha_keystream_cipher_macros.svh.
//
// Each input transaction carries one 64-byte message block; the block comes
// back XORed with one ChaCha keystream block built from the configured key,
// nonce and a 64-bit block counter, which then advances by one and wraps.
// Bytes at or past the valid byte count read as zero, a count above 64 is
// treated as 64, and a block with a count of zero returns all zeros without
// advancing the counter. Setting the restart flag clears the counter before
// the block is processed. Key, key length and nonce are written through the
// configuration channel, which is always ready; write it only while no block
// is in flight. A block occupies the core until its result is in the output
// register, and the next block is accepted only after that: the cycle that ends
// in the accepting edge loads the state, one quarter-round set (four lanes
// working on a column or a diagonal) is iterated once per round, and a finishing
// step performs the feed-forward add and XOR and fills the output register. A
// block with no valid byte applies no round. The finishing step is held for as
// long as the output register still holds a result that the sink has not taken.
// The output register lets the next block be accepted while the previous result
// still waits for the sink.
`include "chacha_keystream_cipher_macros.svh"

module chacha_keystream_cipher import ckc_pkg::*; #(
	parameter int ROUNDS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration write channel.
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// From bit 0: msg_word_0 .. msg_word_7 (64 bits each), valid_bytes (7), one zero pad bit.
	input  logic [519:0] s_tdata,
	// Bit 0: restart.
	input  logic [0:0]   s_tuser,
	// Output stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// From bit 0: out_word_0 .. out_word_7 (64 bits each), out_valid_bytes (7), one zero pad bit.
	output logic [519:0] m_tdata
);

	// After reset the key is all zero and the 256-bit mode is selected.
	localparam ckc_cfg_t CFG_RESET = '{
		key_low_a:  '0,
		key_low_b:  '0,
		key_high_a: '0,
		key_high_b: '0,
		long_key:   1'b1,
		nonce:      '0
	};

	ckc_cfg_t   cfg_q;
	ckc_cmd_t   cmd;
	ckc_stat_t  stat;
	ckc_block_t out_words;
	logic [6:0] out_valid_bytes;

	// The configuration registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_LOW_A:  cfg_q.key_low_a  <= cfg_data;
				REG_KEY_LOW_B:  cfg_q.key_low_b  <= cfg_data;
				REG_KEY_HIGH_A: cfg_q.key_high_a <= cfg_data;
				REG_KEY_HIGH_B: cfg_q.key_high_b <= cfg_data;
				REG_LONG_KEY:   cfg_q.long_key   <= cfg_data[0];
				REG_NONCE:      cfg_q.nonce      <= cfg_data;
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	// The sequencer owns the handshakes; the datapath only follows its commands.
	ckc_ctrl #(
		.ROUNDS(ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid)
	);

	ckc_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg_q),
		.msg             (s_tdata[511:0]),
		.valid_bytes     (s_tdata[518:512]),
		.restart         (s_tuser[0]),
		.stat            (stat),
		.out_words       (out_words),
		.out_valid_bytes (out_valid_bytes)
	);

	assign m_tdata = {1'b0, out_valid_bytes, out_words};

	// Only one block is in flight: after a transaction on the input the block is busy.
	`CKC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "input accepted while a block was in flight")
	// The sequencer never issues two datapath operations in one cycle.
	`CKC_ASSERT_IMPL(a_one_command, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.step, cmd.finish}), "conflicting datapath commands")
	// A finished block is presented in the following cycle.
	`CKC_ASSERT_NEXT(a_finish_presents, clk, arst_n, cmd.finish, m_tvalid, "finished block not presented on the output")
	// The echoed byte count is always saturated to the block size.
	`CKC_ASSERT_IMPL(a_count_range, clk, arst_n, m_tvalid, m_tdata[518:512] <= MAX_BYTES, "output byte count above 64")

endmodule

// ===== dv/tb_chacha_keystream_cipher.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ChaCha keystream cipher top level.
// Depends on ckc_pkg and chacha_keystream_cipher; all stimulus and checking live here.
module tb_chacha_keystream_cipher;
	import ckc_pkg::*;

	localparam int ROUNDS = 8;
	// Cycles to wait after the last output block before touching the key registers.
	localparam int DRAIN_CYCLES = ROUNDS + 4;
	// Register indexes the block does not decode; writes to them must be ignored.
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;
	localparam int RANDOM_PHASES = 8;
	localparam int BLOCKS_PER_PHASE = 250;
	// Limit for a run of about 2000 blocks; it leaves a wide margin over the worst case.
	localparam longint RUN_LIMIT_NS = 64'd5_000_000;

	// One plaintext block as it travels on the input stream.
	typedef struct packed {
		ckc_block_t msg;
		logic [6:0] nbytes;
		logic       restart;
	} pt_block_t;

	// One ciphertext block as it should appear on the output stream.
	typedef struct packed {
		ckc_block_t data;
		logic [6:0] nbytes;
	} ct_block_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [519:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [519:0] m_tdata;

	// Shadow copy of the key registers and of the block counter.
	ckc_cfg_t    key_cfg;
	logic [63:0] block_ctr;

	pt_block_t   plaintext_q[$];
	ct_block_t   ciphertext_q[$];
	pt_block_t   on_bus;
	ct_block_t   want;
	ckc_block_t  got_words;
	logic [6:0]  got_nbytes;
	bit          idle_on;
	int          src_gap;
	int          snk_gap;
	int          mismatches;

	chacha_keystream_cipher #(.ROUNDS(ROUNDS)) DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rotl(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic ckc_state_t quarter(ckc_state_t x, int a, int b, int c, int d);
		x[a] += x[b]; x[d] = rotl(x[d] ^ x[a], 16);
		x[c] += x[d]; x[b] = rotl(x[b] ^ x[c], 12);
		x[a] += x[b]; x[d] = rotl(x[d] ^ x[a], 8);
		x[c] += x[d]; x[b] = rotl(x[b] ^ x[c], 7);
		return x;
	endfunction

	// Encrypts a block with the shadow key and counter; non-empty blocks advance it.
	function automatic ct_block_t chacha_xor(pt_block_t pt);
		ckc_state_t   init;
		ckc_state_t   x;
		logic [511:0] keep;
		ct_block_t    ct;
		int           n;
		if (pt.restart)
			block_ctr = '0;
		n = (pt.nbytes > MAX_BYTES) ? MAX_BYTES : pt.nbytes;
		ct.data = '0;
		ct.nbytes = 7'(n);
		// An empty block yields zeros and leaves the counter where it is.
		if (n == 0)
			return ct;
		init[3:0]   = key_cfg.long_key ? SIGMA : TAU;
		init[5:4]   = key_cfg.key_low_a;
		init[7:6]   = key_cfg.key_low_b;
		init[9:8]   = key_cfg.long_key ? key_cfg.key_high_a : key_cfg.key_low_a;
		init[11:10] = key_cfg.long_key ? key_cfg.key_high_b : key_cfg.key_low_b;
		init[13:12] = block_ctr;
		init[15:14] = key_cfg.nonce;
		x = init;
		for (int r = 0; r < ROUNDS; r++) begin
			if (r % 2 == 0) begin
				x = quarter(x, 0, 4, 8, 12);
				x = quarter(x, 1, 5, 9, 13);
				x = quarter(x, 2, 6, 10, 14);
				x = quarter(x, 3, 7, 11, 15);
			end else begin
				x = quarter(x, 0, 5, 10, 15);
				x = quarter(x, 1, 6, 11, 12);
				x = quarter(x, 2, 7, 8, 13);
				x = quarter(x, 3, 4, 9, 14);
			end
		end
		for (int i = 0; i < 16; i++)
			x[i] += init[i];
		keep = '0;
		for (int b = 0; b < n; b++)
			keep[8 * b +: 8] = 8'hff;
		ct.data = (pt.msg ^ x) & keep;
		block_ctr += 64'd1;
		return ct;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
		case (idx)
			REG_KEY_LOW_A:  key_cfg.key_low_a = val;
			REG_KEY_LOW_B:  key_cfg.key_low_b = val;
			REG_KEY_HIGH_A: key_cfg.key_high_a = val;
			REG_KEY_HIGH_B: key_cfg.key_high_b = val;
			REG_LONG_KEY:   key_cfg.long_key = val[0];
			REG_NONCE:      key_cfg.nonce = val;
			default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string field, logic [63:0] exp_val,
			logic [63:0] act_val);
		$error("%s: expected %h, actual %h", field, exp_val, act_val);
		mismatches++;
	endfunction

	// Random values, a third of them all-zero or all-one, so both extremes get used.
	function automatic logic [63:0] key_word();
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic ckc_block_t random_msg();
		ckc_block_t msg;
		for (int j = 0; j < 8; j++)
			msg[j] = {$urandom, $urandom};
		return msg;
	endfunction

	function automatic pt_block_t random_block();
		pt_block_t blk;
		int        pick;
		for (int j = 0; j < 8; j++)
			blk.msg[j] = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 70)
			blk.nbytes = MAX_BYTES;
		else if (pick < 88)
			blk.nbytes = 7'($urandom_range(1, 63));
		else if (pick < 94)
			blk.nbytes = '0;
		else
			blk.nbytes = 7'($urandom_range(65, 127));
		blk.restart = ($urandom_range(0, 15) == 0);
		return blk;
	endfunction

	function automatic void queue_block(ckc_block_t msg, logic [6:0] nbytes, logic restart);
		pt_block_t blk;
		blk.msg = msg;
		blk.nbytes = nbytes;
		blk.restart = restart;
		plaintext_q.push_back(blk);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	// Holds the sender back until every queued block has come back, then lets the
	// datapath settle so a register write cannot land on a block in flight.
	task automatic drain_all();
		do
			@(negedge clk);
		while (plaintext_q.size() != 0 || s_tvalid || ciphertext_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Input side: presents queued blocks, with random bursts of idle cycles between them.
	// The expected ciphertext is worked out at the edge where a transaction is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				ciphertext_q.push_back(chacha_xor(on_bus));
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (plaintext_q.size() > 0) begin
					on_bus = plaintext_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, on_bus.nbytes, on_bus.msg};
					s_tuser <= on_bus.restart;
					if (idle_on && $urandom_range(0, 7) == 0)
						src_gap = $urandom_range(1, 10);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: stalls in random bursts and checks each accepted transaction
	// against the oldest outstanding ciphertext block.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_words = m_tdata[511:0];
				got_nbytes = m_tdata[518:512];
				if (ciphertext_q.size() == 0) begin
					note_mismatch("unexpected output block, out_valid_bytes", '0,
						64'(got_nbytes));
				end else begin
					want = ciphertext_q.pop_front();
					for (int j = 0; j < 8; j++)
						if (got_words[j] !== want.data[j])
							note_mismatch($sformatf("out_word_%0d", j), want.data[j],
								got_words[j]);
					if (got_nbytes !== want.nbytes)
						note_mismatch("out_valid_bytes", 64'(want.nbytes), 64'(got_nbytes));
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				snk_gap = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		key_cfg = '0;
		key_cfg.long_key = 1'b1;
		block_ctr = '0;
		idle_on = 1'b1;
		mismatches = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset key settings: both extreme messages, short and partial blocks, an
		// empty block, counts above 64, and restarts with and without data.
		@(negedge clk);
		queue_block('0, MAX_BYTES, 1'b0);
		queue_block('1, MAX_BYTES, 1'b0);
		queue_block(random_msg(), 7'd1, 1'b0);
		queue_block(random_msg(), 7'd63, 1'b0);
		queue_block(random_msg(), 7'd8, 1'b0);
		queue_block(random_msg(), 7'd9, 1'b0);
		queue_block(random_msg(), 7'd0, 1'b0);
		queue_block(random_msg(), 7'd65, 1'b0);
		queue_block(random_msg(), 7'd127, 1'b0);
		queue_block(random_msg(), MAX_BYTES, 1'b1);
		queue_block(random_msg(), 7'd0, 1'b1);
		queue_block(random_msg(), MAX_BYTES, 1'b0);
		drain_all();

		// Every key bit set, 256-bit mode, plus writes to the undecoded indexes.
		write_reg(REG_KEY_LOW_A, '1);
		write_reg(REG_KEY_LOW_B, '1);
		write_reg(REG_KEY_HIGH_A, '1);
		write_reg(REG_KEY_HIGH_B, '1);
		write_reg(REG_NONCE, '1);
		write_reg(REG_LONG_KEY, 64'd1);
		write_reg(REG_SPARE_6, '0);
		write_reg(REG_SPARE_7, '1);
		@(negedge clk);
		queue_block('0, MAX_BYTES, 1'b1);
		queue_block('1, MAX_BYTES, 1'b0);
		queue_block(random_msg(), 7'd32, 1'b0);
		drain_all();

		// Same key in 128-bit mode: the high half must be ignored.
		write_reg(REG_LONG_KEY, 64'd0);
		@(negedge clk);
		queue_block('0, MAX_BYTES, 1'b1);
		queue_block('1, MAX_BYTES, 1'b0);
		queue_block(random_msg(), 7'd17, 1'b0);
		drain_all();

		// All-zero key and nonce in 128-bit mode.
		write_reg(REG_KEY_LOW_A, '0);
		write_reg(REG_KEY_LOW_B, '0);
		write_reg(REG_KEY_HIGH_A, '0);
		write_reg(REG_KEY_HIGH_B, '0);
		write_reg(REG_NONCE, '0);
		@(negedge clk);
		queue_block('0, MAX_BYTES, 1'b1);
		queue_block(random_msg(), MAX_BYTES, 1'b0);
		drain_all();

		// Random phases, each with a fresh key setting. One phase in the middle and the
		// last one run with no idle cycles; one phase also pauses the sender halfway.
		// The block counter cannot be preloaded, so its wrap at 2^64 is out of reach.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_reg(REG_KEY_LOW_A, key_word());
			write_reg(REG_KEY_LOW_B, key_word());
			write_reg(REG_KEY_HIGH_A, key_word());
			write_reg(REG_KEY_HIGH_B, key_word());
			write_reg(REG_NONCE, key_word());
			write_reg(REG_LONG_KEY, {$urandom, $urandom});
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
					{$urandom, $urandom});
			idle_on = (ph != 3) && (ph != RANDOM_PHASES - 1);
			@(negedge clk);
			for (int k = 0; k < BLOCKS_PER_PHASE; k++) begin
				if (ph == 2 && k == BLOCKS_PER_PHASE / 2)
					drain_all();
				plaintext_q.push_back(random_block());
			end
			drain_all();
		end

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ckc_pkg.sv
hw/rtl/ckc_ctrl.sv
hw/rtl/ckc_datapath.sv
hw/rtl/chacha_keystream_cipher.sv
dv/tb_chacha_keystream_cipher.sv
